// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the vertex transform rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VRTP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("vrtp: implication check failed");

// next-cycle implication, disabled during reset
`define VRTP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("vrtp: next-cycle check failed");

`endif

// ----- hw/rtl/vrtp_pkg.sv -----
// shared constants, types and helper functions of the vertex transform
// no dependencies; used by the matrix builder, divider cell and top level
package vrtp_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int PROJ_SHIFT = 8;
  localparam int SCREEN_W   = 320;
  localparam int SCREEN_H   = 240;

  localparam int CW     = 16;                   // coordinate and coefficient width
  localparam int TRIG_W = FRAC_BITS + 2;        // signed sine value, magnitude up to 1.0
  localparam int QW     = 2 * CW - FRAC_BITS;   // width of a shifted q product
  localparam int PROD_W = 2 * CW;
  localparam int SUM_W  = PROD_W + 2;           // three-term dot product
  localparam int ROT_W  = SUM_W - FRAC_BITS;
  localparam int XYZ_W  = ROT_W + 1;            // after offset add
  localparam int NUM_W  = XYZ_W + PROJ_SHIFT;   // dividend magnitude, one cell per bit
  localparam int REM_W  = XYZ_W;
  localparam int WIDE_W = 40;                   // saturation input width

  typedef enum logic [7:0] {
    CFG_ANGLE_X  = 8'd0,
    CFG_ANGLE_Y  = 8'd1,
    CFG_ANGLE_Z  = 8'd2,
    CFG_OFFSET_X = 8'd3,
    CFG_OFFSET_Y = 8'd4,
    CFG_OFFSET_Z = 8'd5
  } cfg_reg_t;

  // first quadrant of the sine table, q12
  localparam logic [12:0] QUARTER [0:64] = '{
    13'd0,    13'd101,  13'd201,  13'd301,  13'd401,  13'd501,  13'd601,  13'd700,
    13'd799,  13'd897,  13'd995,  13'd1092, 13'd1189, 13'd1285, 13'd1380, 13'd1474,
    13'd1567, 13'd1660, 13'd1751, 13'd1842, 13'd1931, 13'd2019, 13'd2106, 13'd2191,
    13'd2276, 13'd2359, 13'd2440, 13'd2520, 13'd2598, 13'd2675, 13'd2751, 13'd2824,
    13'd2896, 13'd2967, 13'd3035, 13'd3102, 13'd3166, 13'd3229, 13'd3290, 13'd3349,
    13'd3406, 13'd3461, 13'd3513, 13'd3564, 13'd3612, 13'd3659, 13'd3703, 13'd3745,
    13'd3784, 13'd3822, 13'd3857, 13'd3889, 13'd3920, 13'd3948, 13'd3973, 13'd3996,
    13'd4017, 13'd4036, 13'd4052, 13'd4065, 13'd4076, 13'd4085, 13'd4091, 13'd4095,
    13'd4096
  };

  // divider word handed from cell to cell
  typedef struct packed {
    logic                    front;
    logic                    fin;
    logic                    x_neg;
    logic                    y_neg;
    logic [REM_W-1:0]        den;
    logic signed [XYZ_W-1:0] x;
    logic signed [XYZ_W-1:0] y;
    logic signed [XYZ_W-1:0] z;
    logic [NUM_W-1:0]        num_x;
    logic [NUM_W-1:0]        num_y;
    logic [NUM_W-1:0]        quo_x;
    logic [NUM_W-1:0]        quo_y;
    logic [REM_W-1:0]        rem_x;
    logic [REM_W-1:0]        rem_y;
  } div_word_t;

  function automatic logic signed [TRIG_W-1:0] sine(input logic [7:0] k);
    logic [6:0]  idx;
    logic [12:0] mag;
    idx = k[6] ? (7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
    mag = QUARTER[idx];
    return k[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [QW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return p[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic logic signed [CW-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

endpackage

// ----- hw/rtl/vrtp_matrix.sv -----
// rotation matrix builder: three-step sequence after an angle write
// depends on vrtp_pkg (sine table, qmul, sat16)
module vrtp_matrix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [7:0]              angle_x,
  input  logic [7:0]              angle_y,
  input  logic [7:0]              angle_z,
  output logic signed [15:0]      coeff [0:8],
  output logic                    busy
);

  logic s1, s2, s3;
  logic signed [15:0] sx, sy, sz, cx, cy, cz;
  logic signed [15:0] cycz, cysz, sxcy, cxcy, cxcz, sxsz, cxsz, sxsy, cxsy, nsxcz;

  assign busy = s1 | s2 | s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
      s3 <= 1'b0;
    end else begin
      s1 <= start;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // table lookups
  always_ff @(posedge clk) begin
    if (s1) begin
      sx <= 16'(vrtp_pkg::sine(angle_x));
      sy <= 16'(vrtp_pkg::sine(angle_y));
      sz <= 16'(vrtp_pkg::sine(angle_z));
      cx <= 16'(vrtp_pkg::sine(angle_x + 8'd64));
      cy <= 16'(vrtp_pkg::sine(angle_y + 8'd64));
      cz <= 16'(vrtp_pkg::sine(angle_z + 8'd64));
    end
  end

  // pairwise products
  always_ff @(posedge clk) begin
    if (s2) begin
      cycz  <= 16'(vrtp_pkg::qmul(cy, cz));
      cysz  <= 16'(vrtp_pkg::qmul(cy, sz));
      sxcy  <= 16'(vrtp_pkg::qmul(sx, cy));
      cxcy  <= 16'(vrtp_pkg::qmul(cx, cy));
      cxcz  <= 16'(vrtp_pkg::qmul(cx, cz));
      sxsz  <= 16'(vrtp_pkg::qmul(sx, sz));
      cxsz  <= 16'(vrtp_pkg::qmul(cx, sz));
      sxsy  <= 16'(vrtp_pkg::qmul(sx, sy));
      cxsy  <= 16'(vrtp_pkg::qmul(cx, sy));
      nsxcz <= 16'(vrtp_pkg::qmul(-sx, cz));
    end
  end

  // triple products and final sums
  always_ff @(posedge clk) begin
    if (rst) begin
      // identity: ones on the diagonal
      for (int i = 0; i < 9; i++) begin
        coeff[i] <= (i == 0 || i == 4 || i == 8) ? 16'sd4096 : 16'sd0;
      end
    end else if (s3) begin
      coeff[0] <= vrtp_pkg::sat16(40'(cycz));
      coeff[1] <= vrtp_pkg::sat16(40'(vrtp_pkg::qmul(sxsy, cz)) - 40'(cxsz));
      coeff[2] <= vrtp_pkg::sat16(40'(vrtp_pkg::qmul(cxsy, cz)) + 40'(sxsz));
      coeff[3] <= vrtp_pkg::sat16(40'(cysz));
      coeff[4] <= vrtp_pkg::sat16(40'(cxcz) + 40'(vrtp_pkg::qmul(sxsy, sz)));
      coeff[5] <= vrtp_pkg::sat16(40'(nsxcz) + 40'(vrtp_pkg::qmul(cxsy, sz)));
      coeff[6] <= vrtp_pkg::sat16(-40'(sy));
      coeff[7] <= vrtp_pkg::sat16(40'(sxcy));
      coeff[8] <= vrtp_pkg::sat16(40'(cxcy));
    end
  end

endmodule

// ----- hw/rtl/vrtp_div_cell.sv -----
// one restoring-division cell: one quotient bit for x and for y per stage
// depends on vrtp_pkg (div_word_t)
module vrtp_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrtp_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output vrtp_pkg::div_word_t out_word
);

  localparam int RW = vrtp_pkg::REM_W;
  localparam int NW = vrtp_pkg::NUM_W;

  logic                load;
  logic [RW:0]         tx, ty, dx, dy;
  logic                gx, gy;
  vrtp_pkg::div_word_t nxt;

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_comb begin
    tx  = {in_word.rem_x, in_word.num_x[NW-1]};
    ty  = {in_word.rem_y, in_word.num_y[NW-1]};
    dx  = tx - {1'b0, in_word.den};
    dy  = ty - {1'b0, in_word.den};
    gx  = tx >= {1'b0, in_word.den};
    gy  = ty >= {1'b0, in_word.den};
    nxt = in_word;
    nxt.rem_x = gx ? dx[RW-1:0] : tx[RW-1:0];
    nxt.rem_y = gy ? dy[RW-1:0] : ty[RW-1:0];
    nxt.num_x = {in_word.num_x[NW-2:0], 1'b0};
    nxt.num_y = {in_word.num_y[NW-2:0], 1'b0};
    nxt.quo_x = {in_word.quo_x[NW-2:0], gx};
    nxt.quo_y = {in_word.quo_y[NW-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= nxt;
    end
  end

endmodule

// ----- hw/rtl/vertex_rotate_translate_project_top.sv -----
// top level of the vertex rotate, translate and project unit
// depends on vrtp_pkg, vrtp_matrix, vrtp_div_cell and assert_macros.svh
//
// usage
//   s_axis_*  : one model vertex per transfer, tlast marks the last vertex of a mesh
//   m_axis_*  : one screen vertex per transfer, tuser set when projected, tlast copied
//   cfg_*     : register writes (index 0..5: angle x/y/z, offset x/y/z), cfg_ready
//               is always high, out-of-range indexes are dropped
// pipeline: multiply stage, dot product and offset stage, 31 divider cells,
//   output register
// throughput: one vertex per cycle while no matrix rebuild runs and the receiver
//   keeps up; the row of divider cells, one quotient bit per cell, sets the depth
// an angle write rebuilds the matrix in a 3-step sequence, s_axis_tready is low
//   while the rebuild runs
// reset: angles and offsets clear, matrix goes to identity, pipeline empties
// receiver stall: each stage holds only while the one after it is full, so
//   bubbles close up and the input keeps going until the pipeline is full
`include "assert_macros.svh"

module vertex_rotate_translate_project_top (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // model_x, model_y, model_z
  input  logic        s_axis_tlast,   // final_vertex
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // screen_x, screen_y, view_depth
  output logic        m_axis_tuser,   // in_front
  output logic        m_axis_tlast,   // final_out
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NW  = vrtp_pkg::NUM_W;
  localparam int XW  = vrtp_pkg::XYZ_W;
  localparam int SW  = vrtp_pkg::SUM_W;
  localparam int FB  = vrtp_pkg::FRAC_BITS;
  localparam int PS  = vrtp_pkg::PROJ_SHIFT;

  // configuration registers
  logic [7:0]         angle_x, angle_y, angle_z;
  logic signed [15:0] offset [0:2];
  logic               cfg_fire, angle_wr;

  logic signed [15:0] coeff [0:8];
  logic               mat_busy;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x   <= 8'd0;
      angle_y   <= 8'd0;
      angle_z   <= 8'd0;
      offset[0] <= 16'sd0;
      offset[1] <= 16'sd0;
      offset[2] <= 16'sd0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        vrtp_pkg::CFG_ANGLE_X:  angle_x   <= cfg_data[7:0];
        vrtp_pkg::CFG_ANGLE_Y:  angle_y   <= cfg_data[7:0];
        vrtp_pkg::CFG_ANGLE_Z:  angle_z   <= cfg_data[7:0];
        vrtp_pkg::CFG_OFFSET_X: offset[0] <= cfg_data;
        vrtp_pkg::CFG_OFFSET_Y: offset[1] <= cfg_data;
        vrtp_pkg::CFG_OFFSET_Z: offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // an angle write kicks the matrix rebuild
  assign angle_wr = cfg_fire && !rst &&
                    (cfg_index == vrtp_pkg::CFG_ANGLE_X ||
                     cfg_index == vrtp_pkg::CFG_ANGLE_Y ||
                     cfg_index == vrtp_pkg::CFG_ANGLE_Z);

  vrtp_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .start   (angle_wr),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .coeff   (coeff),
    .busy    (mat_busy)
  );

  // handshake chain: stage 0 of words is the dot product stage
  logic                r1_valid, r1_fin, load_r1, load_r2, s_fire;
  logic signed [31:0]  r1_prod [0:8];
  logic signed [15:0]  mvec [0:2];
  logic                vld [0:NW];
  logic                rdy [0:NW];
  vrtp_pkg::div_word_t words [0:NW];
  vrtp_pkg::div_word_t r2_word;

  assign mvec[0] = s_axis_tdata[15:0];
  assign mvec[1] = s_axis_tdata[31:16];
  assign mvec[2] = s_axis_tdata[47:32];

  assign load_r2       = !vld[0] || rdy[0];
  assign load_r1       = !r1_valid || load_r2;
  assign s_axis_tready = load_r1 && !mat_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // multiply stage: nine products of coordinate and coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (load_r1) begin
      r1_valid <= s_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (load_r1) begin
      r1_fin <= s_axis_tlast;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          r1_prod[3*r+c] <= mvec[c] * coeff[3*r+c];
        end
      end
    end
  end

  // dot product, offset add and divider preload
  logic signed [SW-1:0] dsum [0:2];
  logic signed [XW-1:0] pos  [0:2];
  logic [XW-1:0]        mag_x, mag_y;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dsum[r] = SW'(r1_prod[3*r]) + SW'(r1_prod[3*r+1]) + SW'(r1_prod[3*r+2]);
      // floor shift keeps the sign of the dot product
      pos[r]  = XW'($signed(dsum[r][SW-1:FB])) + XW'(offset[r]);
    end
    mag_x = pos[0][XW-1] ? XW'(-pos[0]) : XW'(pos[0]);
    mag_y = pos[1][XW-1] ? XW'(-pos[1]) : XW'(pos[1]);
    r2_word       = '0;
    r2_word.front = pos[2] > 0;
    r2_word.fin   = r1_fin;
    r2_word.x_neg = pos[0][XW-1];
    r2_word.y_neg = pos[1][XW-1];
    r2_word.den   = pos[2];
    r2_word.x     = pos[0];
    r2_word.y     = pos[1];
    r2_word.z     = pos[2];
    r2_word.num_x = {mag_x, PS'(0)};
    r2_word.num_y = {mag_y, PS'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (load_r2) begin
      vld[0] <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_r2) begin
      words[0] <= r2_word;
    end
  end

  // row of divider cells, msb of the quotient first
  for (genvar k = 0; k < NW; k++) begin : g_cell
    vrtp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_word   (words[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_word  (words[k+1])
    );
  end

  // output register: sign, centering and y flip for projected vertices, saturation
  vrtp_pkg::div_word_t  lw;
  logic signed [NW:0]   qx, qy;
  logic signed [39:0]   wx, wy;
  logic                 load_out;

  assign lw       = words[NW];
  assign load_out = !m_axis_tvalid || m_axis_tready;
  assign rdy[NW]  = load_out;

  always_comb begin
    qx = lw.x_neg ? -$signed({1'b0, lw.quo_x}) : $signed({1'b0, lw.quo_x});
    qy = lw.y_neg ? -$signed({1'b0, lw.quo_y}) : $signed({1'b0, lw.quo_y});
    if (lw.front) begin
      wx = 40'(vrtp_pkg::SCREEN_W / 2) + 40'(qx);
      wy = 40'(vrtp_pkg::SCREEN_H / 2) - 40'(qy);
    end else begin
      wx = 40'(lw.x);
      wy = 40'(lw.y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata[15:0]  <= vrtp_pkg::sat16(wx);
      m_axis_tdata[31:16] <= vrtp_pkg::sat16(wy);
      m_axis_tdata[47:32] <= vrtp_pkg::sat16(40'(lw.z));
      m_axis_tuser        <= lw.front;
      m_axis_tlast        <= lw.fin;
    end
  end

  // checks
  `VRTP_ASSERT_IMP(a_busy_blocks_input, clk, rst, mat_busy, !s_axis_tready)
  `VRTP_ASSERT_NXT(a_angle_write_rebuilds, clk, rst, angle_wr, mat_busy)
  `VRTP_ASSERT_IMP(a_front_depth_positive, clk, rst, m_axis_tvalid && m_axis_tuser, $signed(m_axis_tdata[47:32]) > 0)

endmodule
